[hw/rtl/wca_pkg.sv]
// ----------------------------------------------------------------------------
// wca_pkg: shared types and constants of the co-occurrence accumulator
// Request codes, internal command kinds, field widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package wca_pkg;

    // fixed field widths
    localparam int unsigned FIELD_W   = 6;
    localparam int unsigned REQ_W     = 2;
    localparam int unsigned WIN_W     = 5;
    localparam int unsigned SUM_W     = 32;
    localparam int unsigned WEIGHT_W  = 17;

    // parameter defaults
    localparam int unsigned VOCAB_DEFAULT      = 64;
    localparam int unsigned MAX_WINDOW_DEFAULT = 16;

    // command queue depth
    localparam int unsigned QUEUE_DEPTH = 4;

    // window length after reset
    localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd10;

    // request codes on the input port
    localparam logic [REQ_W-1:0] REQ_WORD = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EOL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

    // command kinds carried through the queue
    typedef enum logic [1:0] {
        CMD_WORD,
        CMD_EOL,
        CMD_READ
    } cmd_kind_t;

    localparam int unsigned KIND_W = 2;

endpackage

`default_nettype wire

[hw/rtl/wca_front.sv]
// ----------------------------------------------------------------------------
// wca_front: request intake
// Accepts requests, classifies them into commands and folds indices into
// the vocabulary range before they enter the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wca_front
    import wca_pkg::*;
#(
    parameter int unsigned VOCAB = VOCAB_DEFAULT,
    parameter int unsigned IDX_W = $clog2(VOCAB)
)
(
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [REQ_W-1:0]   req_type,
    input  wire logic [FIELD_W-1:0] word_index,
    input  wire logic [FIELD_W-1:0] row_index,
    input  wire logic [FIELD_W-1:0] col_index,
    output logic                    push,
    output cmd_kind_t               kind,
    output logic [IDX_W-1:0]        idx_a,
    output logic [IDX_W-1:0]        idx_b
);

    localparam int unsigned FOLD_N = 2 ** FIELD_W;

    // index fold table, built at elaboration
    logic [IDX_W-1:0] fold_lut [FOLD_N];

    for (genvar g = 0; g < FOLD_N; g++) begin : g_fold
        localparam int unsigned Folded = g % VOCAB;
        assign fold_lut[g] = IDX_W'(Folded);
    end

    // request decode
    always_comb
    begin
        push  = 1'b0;
        kind  = CMD_EOL;
        idx_a = fold_lut[word_index];
        idx_b = fold_lut[col_index];
        unique case (req_type)
            REQ_WORD:
            begin
                push  = start && !busy;
                kind  = CMD_WORD;
                idx_a = fold_lut[word_index];
            end
            REQ_EOL:
            begin
                push  = start && !busy;
                kind  = CMD_EOL;
            end
            REQ_READ:
            begin
                push  = start && !busy;
                kind  = CMD_READ;
                idx_a = fold_lut[row_index];
                idx_b = fold_lut[col_index];
            end
            default:
            begin
                // unused code: taken and dropped
                push  = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/wca_queue.sv]
// ----------------------------------------------------------------------------
// wca_queue: command queue
// Small first-in first-out buffer between the intake and the update engine.
// ----------------------------------------------------------------------------
`default_nettype none

module wca_queue
    import wca_pkg::*;
#(
    parameter int unsigned DATA_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      pop_data,
    output logic                   empty,
    output logic                   full
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    logic              do_push;
    logic              do_pop;

    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/wca_back.sv]
// ----------------------------------------------------------------------------
// wca_back: update engine
// Clears the pair store after reset, then runs commands from the queue:
// read-modify-write of pair sums for each word, history upkeep, lookups.
// ----------------------------------------------------------------------------
`default_nettype none

module wca_back
    import wca_pkg::*;
#(
    parameter int unsigned VOCAB      = VOCAB_DEFAULT,
    parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEFAULT,
    parameter int unsigned IDX_W      = $clog2(VOCAB)
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [WIN_W-1:0] window_length,
    input  wire logic             cmd_valid,
    input  wire cmd_kind_t        cmd_kind,
    input  wire logic [IDX_W-1:0] cmd_a,
    input  wire logic [IDX_W-1:0] cmd_b,
    output logic                  cmd_pop,
    output logic                  clearing,
    output logic                  result_valid,
    output logic [SUM_W-1:0]      weight_sum,
    output logic                  saturated
);

    localparam int unsigned PAIRS = VOCAB * VOCAB;
    localparam int unsigned AW    = $clog2(PAIRS);
    localparam int unsigned HP_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int unsigned RW    = CNT_W + 1;
    localparam int unsigned LW    = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_RD,
        ST_WR,
        ST_FIN,
        ST_LOOKUP,
        ST_RESP
    } state_t;

    // distance weights, round half up of 65536 / d
    logic [WEIGHT_W-1:0] weight_lut [MAX_WINDOW];

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_weight
        localparam int unsigned Wgt = (131072 + g + 1) / (2 * (g + 1));
        assign weight_lut[g] = WEIGHT_W'(Wgt);
    end

    // pair store: {sticky saturation bit, sum}
    logic [SUM_W:0]    pair_mem [PAIRS];
    logic [SUM_W:0]    mem_q;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [SUM_W:0]    mem_wdata;

    // history ring
    logic [IDX_W-1:0]  hist_mem [MAX_WINDOW];
    logic [IDX_W-1:0]  hist_q;
    logic              hist_we;
    logic [HP_W-1:0]   hist_raddr;

    // control registers
    state_t            state_reg;
    state_t            state_next;
    logic [AW-1:0]     clr_reg;
    logic [AW-1:0]     clr_next;
    logic [IDX_W-1:0]  word_reg;
    logic [IDX_W-1:0]  word_next;
    logic [IDX_W-1:0]  other_reg;
    logic [IDX_W-1:0]  other_next;
    logic [CNT_W-1:0]  lim_reg;
    logic [CNT_W-1:0]  lim_next;
    logic [CNT_W-1:0]  d_reg;
    logic [CNT_W-1:0]  d_next;
    logic [HP_W-1:0]   wp_reg;
    logic [HP_W-1:0]   wp_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [AW-1:0]     slot_reg;
    logic [AW-1:0]     slot_next;
    logic [WEIGHT_W-1:0] wgt_reg;
    logic [WEIGHT_W-1:0] wgt_next;

    // datapath helpers
    logic [IDX_W-1:0]  pair_x;
    logic [IDX_W-1:0]  pair_y;
    logic [IDX_W-1:0]  pair_lo;
    logic [IDX_W-1:0]  pair_hi;
    logic [AW-1:0]     slot_comb;
    logic [SUM_W:0]    add_full;
    logic [SUM_W:0]    upd_data;
    logic [LW-1:0]     lim_calc;
    logic [CNT_W-1:0]  d_sel;
    logic [RW-1:0]     hist_raw;

    assign clearing     = (state_reg == ST_CLEAR);
    assign result_valid = (state_reg == ST_RESP);
    assign weight_sum   = mem_q[SUM_W-1:0];
    assign saturated    = mem_q[SUM_W];

    // pair slot at (min, max)
    always_comb
    begin
        pair_lo   = (pair_x < pair_y) ? pair_x : pair_y;
        pair_hi   = (pair_x < pair_y) ? pair_y : pair_x;
        slot_comb = AW'(pair_lo) * AW'(VOCAB) + AW'(pair_hi);
    end

    // saturating accumulate with sticky flag
    always_comb
    begin
        add_full = {1'b0, mem_q[SUM_W-1:0]} + (SUM_W + 1)'(wgt_reg);
        if (add_full[SUM_W])
        begin
            upd_data = {1'b1, {SUM_W{1'b1}}};
        end
        else
        begin
            upd_data = {mem_q[SUM_W], add_full[SUM_W-1:0]};
        end
    end

    // pairing limit: min of window, ring size and history fill
    always_comb
    begin
        lim_calc = LW'(window_length);
        if (lim_calc > LW'(MAX_WINDOW))
        begin
            lim_calc = LW'(MAX_WINDOW);
        end
        if (lim_calc > LW'(count_reg))
        begin
            lim_calc = LW'(count_reg);
        end
    end

    // history read address: newest entry minus distance, wrapped
    always_comb
    begin
        d_sel    = (d_reg >= CNT_W'(MAX_WINDOW)) ? '0 : d_reg;
        hist_raw = RW'(wp_reg) + RW'(MAX_WINDOW - 1) - RW'(d_sel);
        if (hist_raw >= RW'(MAX_WINDOW))
        begin
            hist_raw = hist_raw - RW'(MAX_WINDOW);
        end
        hist_raddr = HP_W'(hist_raw);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        word_next  = word_reg;
        other_next = other_reg;
        lim_next   = lim_reg;
        d_next     = d_reg;
        wp_next    = wp_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        wgt_next   = wgt_reg;
        cmd_pop    = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = slot_reg;
        mem_wdata  = upd_data;
        hist_we    = 1'b0;
        pair_x     = word_reg;
        pair_y     = hist_q;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == AW'(PAIRS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd_kind)
                        CMD_WORD:
                        begin
                            word_next  = cmd_a;
                            d_next     = '0;
                            lim_next   = CNT_W'(lim_calc);
                            state_next = ST_PREP;
                        end
                        CMD_READ:
                        begin
                            word_next  = cmd_a;
                            other_next = cmd_b;
                            state_next = ST_LOOKUP;
                        end
                        default:
                        begin
                            // end of line
                            count_next = '0;
                        end
                    endcase
                end
            end
            ST_PREP:
            begin
                // history entry at distance one is read this cycle
                state_next = (lim_reg == '0) ? ST_FIN : ST_RD;
            end
            ST_RD:
            begin
                slot_next  = slot_comb;
                wgt_next   = weight_lut[d_reg[HP_W-1:0]];
                d_next     = d_reg + 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                mem_we     = 1'b1;
                state_next = (d_reg == lim_reg) ? ST_FIN : ST_RD;
            end
            ST_FIN:
            begin
                hist_we    = 1'b1;
                wp_next    = (wp_reg == HP_W'(MAX_WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                if (count_reg != CNT_W'(MAX_WINDOW))
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_LOOKUP:
            begin
                pair_y     = other_reg;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            word_reg  <= '0;
            other_reg <= '0;
            lim_reg   <= '0;
            d_reg     <= '0;
            wp_reg    <= '0;
            count_reg <= '0;
            slot_reg  <= '0;
            wgt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            word_reg  <= word_next;
            other_reg <= other_next;
            lim_reg   <= lim_next;
            d_reg     <= d_next;
            wp_reg    <= wp_next;
            count_reg <= count_next;
            slot_reg  <= slot_next;
            wgt_reg   <= wgt_next;
        end
    end

    // pair store port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pair_mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= pair_mem[slot_comb];
    end

    // history ring port
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[wp_reg] <= word_reg;
        end
        hist_q <= hist_mem[hist_raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/windowed_cooccurrence_accumulator.sv]
// ----------------------------------------------------------------------------
// windowed_cooccurrence_accumulator: distance-weighted pair counter
// Pairs each word with the preceding words of its line and accumulates
// saturating Q16.16 reciprocal-distance weights per unordered word pair.
// ----------------------------------------------------------------------------
// usage
//   requests enter on start/busy: a request is taken on a clock edge with
//   start high and busy low. req_type picks word, end of line or read.
//   requests pass a QUEUE_DEPTH-entry command queue to the update engine.
//   a read returns weight_sum and saturated for one cycle under
//   result_valid, after the engine has popped it from the queue and looked it up.
//   word requests produce no result; the engine handles each pair of a
//   word (up to MAX_WINDOW pairs) as a read-modify-write of the pair store,
//   then records the word in the line history.
//   the user writes window_length over cfg_valid/cfg_ready only while
//   the block idles; the block itself does not enforce this.
//   reset: all VOCAB*VOCAB pair store entries are cleared, with busy
//   high throughout; window_length returns to 10, the line history empties.
//   results cannot be held off: the receiver takes each strobed result.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_cooccurrence_accumulator
    import wca_pkg::*;
#(
    parameter int unsigned VOCAB      = VOCAB_DEFAULT,
    parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [REQ_W-1:0]   req_type,
    input  wire logic [FIELD_W-1:0] word_index,
    input  wire logic [FIELD_W-1:0] row_index,
    input  wire logic [FIELD_W-1:0] col_index,
    output logic                    result_valid,
    output logic [SUM_W-1:0]        weight_sum,
    output logic                    saturated,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [WIN_W-1:0]   window_length
);

    localparam int unsigned IDX_W  = $clog2(VOCAB);
    localparam int unsigned DATA_W = KIND_W + 2 * IDX_W;

    logic [WIN_W-1:0]  window_reg;
    logic              push;
    cmd_kind_t         push_kind;
    logic [IDX_W-1:0]  push_a;
    logic [IDX_W-1:0]  push_b;
    logic [DATA_W-1:0] push_data;
    logic [DATA_W-1:0] pop_data;
    logic              pop;
    logic              q_empty;
    logic              q_full;
    logic              clearing;
    cmd_kind_t         pop_kind;
    logic [IDX_W-1:0]  pop_a;
    logic [IDX_W-1:0]  pop_b;

    assign busy      = q_full || clearing;
    assign cfg_ready = 1'b1;

    // window length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            window_reg <= window_length;
        end
    end

    // intake
    wca_front #(
        .VOCAB (VOCAB),
        .IDX_W (IDX_W)
    ) u_front (
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .word_index (word_index),
        .row_index  (row_index),
        .col_index  (col_index),
        .push       (push),
        .kind       (push_kind),
        .idx_a      (push_a),
        .idx_b      (push_b)
    );

    assign push_data = {push_kind, push_a, push_b};

    // command queue
    wca_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign pop_kind = cmd_kind_t'(pop_data[DATA_W-1 -: KIND_W]);
    assign pop_a    = pop_data[2*IDX_W-1 -: IDX_W];
    assign pop_b    = pop_data[IDX_W-1:0];

    // update engine
    wca_back #(
        .VOCAB      (VOCAB),
        .MAX_WINDOW (MAX_WINDOW),
        .IDX_W      (IDX_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (window_reg),
        .cmd_valid     (!q_empty),
        .cmd_kind      (pop_kind),
        .cmd_a         (pop_a),
        .cmd_b         (pop_b),
        .cmd_pop       (pop),
        .clearing      (clearing),
        .result_valid  (result_valid),
        .weight_sum    (weight_sum),
        .saturated     (saturated)
    );

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the windowed co-occurrence accumulator
// Sends word, end-of-line, read and unused requests in paced bursts and
// predicts every read from a local model of the line history and pair store.
// Covers the window extremes and history that outlives a window change.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wca_pkg::*;

    localparam int unsigned VOCAB          = 64;
    localparam int unsigned MAX_WIN        = 16;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned SETTLE_CYCLES  = 300;
    localparam int unsigned PHASE_REQUESTS = 58;

    // request code the block ignores
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             sat;
    } read_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [REQ_W-1:0]   req_type;
    logic [FIELD_W-1:0] word_index;
    logic [FIELD_W-1:0] row_index;
    logic [FIELD_W-1:0] col_index;
    logic               result_valid;
    logic [SUM_W-1:0]   weight_sum;
    logic               saturated;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [WIN_W-1:0]   window_length;

    // predicted block state
    logic [SUM_W-1:0]    pair_total [VOCAB*VOCAB];
    bit                  pair_sat_flag [VOCAB*VOCAB];
    logic [FIELD_W-1:0]  line_history [MAX_WIN];
    int unsigned         line_depth;
    logic [WIN_W-1:0]    window_setting;
    logic [WEIGHT_W-1:0] weight_rom [MAX_WIN];
    read_result_t        pending_reads [$];
    read_result_t        oldest_read;

    int unsigned mismatch_count;
    int unsigned idle_cycles;
    bit          pacing_on;
    int unsigned burst_left;

    windowed_cooccurrence_accumulator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .word_index   (word_index),
        .row_index    (row_index),
        .col_index    (col_index),
        .result_valid (result_valid),
        .weight_sum   (weight_sum),
        .saturated    (saturated),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .window_length(window_length)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic int unsigned pair_address(input logic [FIELD_W-1:0] a,
                                                 input logic [FIELD_W-1:0] b);
        int unsigned lo;
        int unsigned hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return lo * VOCAB + hi;
    endfunction

    // saturating add of one distance weight, sticky overflow flag
    function automatic void accumulate_pair(input logic [FIELD_W-1:0] a,
                                            input logic [FIELD_W-1:0] b,
                                            input logic [WEIGHT_W-1:0] weight);
        int unsigned      slot;
        logic [SUM_W:0]   total;
        slot  = pair_address(a, b);
        total = {1'b0, pair_total[slot]} + weight;
        if (total[SUM_W])
        begin
            pair_total[slot]    = '1;
            pair_sat_flag[slot] = 1'b1;
        end
        else
        begin
            pair_total[slot] = total[SUM_W-1:0];
        end
    endfunction

    function automatic void predict_request(input logic [REQ_W-1:0]   req,
                                            input logic [FIELD_W-1:0] w,
                                            input logic [FIELD_W-1:0] r,
                                            input logic [FIELD_W-1:0] c);
        int unsigned  span;
        int           d;
        read_result_t res;
        case (req)
            REQ_WORD:
            begin
                // window capped at the history size and at the words seen so far
                span = window_setting;
                if (span > MAX_WIN)
                    span = MAX_WIN;
                if (span > line_depth)
                    span = line_depth;
                for (d = 0; d < span; d++)
                    accumulate_pair(w, line_history[d], weight_rom[d]);
                for (d = MAX_WIN - 1; d > 0; d--)
                    line_history[d] = line_history[d-1];
                line_history[0] = w;
                if (line_depth < MAX_WIN)
                    line_depth++;
            end
            REQ_EOL:
            begin
                line_depth = 0;
            end
            REQ_READ:
            begin
                res.sum = pair_total[pair_address(r, c)];
                res.sat = pair_sat_flag[pair_address(r, c)];
                pending_reads = {pending_reads, res};
            end
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // one request, with random bursts and gaps when pacing is on
    task automatic send_request(input logic [REQ_W-1:0]   req,
                                input logic [FIELD_W-1:0] w,
                                input logic [FIELD_W-1:0] r,
                                input logic [FIELD_W-1:0] c);
        int unsigned gap;
        if (pacing_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        start      <= 1'b1;
        req_type   <= req;
        word_index <= w;
        row_index  <= r;
        col_index  <= c;
        do
            @(posedge clk);
        while (busy);
        predict_request(req, w, r, c);
    endtask

    task automatic send_word(input logic [FIELD_W-1:0] w);
        send_request(REQ_WORD, w, FIELD_W'($urandom), FIELD_W'($urandom));
    endtask

    task automatic send_eol();
        send_request(REQ_EOL, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
    endtask

    task automatic send_read(input logic [FIELD_W-1:0] r, input logic [FIELD_W-1:0] c);
        send_request(REQ_READ, FIELD_W'($urandom), r, c);
    endtask

    // stop sending, wait for every read, then let queued words finish
    task automatic drain_block();
        @(negedge clk);
        start <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] value);
        @(negedge clk);
        cfg_valid     <= 1'b1;
        window_length <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        window_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // cleared store, reset window of ten, both read orders, unused code
    task automatic test_reset_defaults();
        logic [FIELD_W-1:0] line_words [12];
        int i;
        line_words = '{6'd0, 6'd63, 6'd21, 6'd42, 6'd63, 6'd0,
                       6'd7, 6'd56, 6'd1, 6'd62, 6'd0, 6'd63};
        send_read(6'd0, 6'd0);
        send_read(6'd63, 6'd63);
        for (i = 0; i < 12; i++)
            send_word(line_words[i]);
        send_eol();
        send_read(6'd0, 6'd63);
        send_read(6'd63, 6'd0);
        send_read(6'd63, 6'd63);
        send_read(6'd0, 6'd0);
        send_request(REQ_UNUSED, 6'd63, 6'd63, 6'd63);
        send_read(6'd42, 6'd21);
    endtask

    // window zero pairs nothing but still records the words
    task automatic test_window_zero();
        drain_block();
        write_window(5'd0);
        send_word(6'd9);
        send_word(6'd9);
        send_word(6'd40);
        send_read(6'd9, 6'd9);
        send_read(6'd40, 6'd9);
        drain_block();
        write_window(5'd1);
        send_word(6'd40);
        send_read(6'd40, 6'd40);
        send_eol();
    endtask

    // lines of random words in phases with different window settings
    task automatic test_random_traffic();
        logic [WIN_W-1:0]   phase_windows [8];
        logic [FIELD_W-1:0] pool [4];
        logic [FIELD_W-1:0] line_words [$];
        logic [FIELD_W-1:0] w;
        int unsigned        sent;
        int unsigned        len;
        bit                 small_pool;
        int                 phase;
        int                 i;
        phase_windows = '{5'd1, 5'd16, 5'd17, 5'd31, 5'd0, 5'd10, 5'd0, 5'd0};
        phase_windows[6] = WIN_W'($urandom_range(0, 31));
        phase_windows[7] = WIN_W'($urandom_range(2, 15));
        for (phase = 0; phase < 8; phase++)
        begin
            drain_block();
            write_window(phase_windows[phase]);
            sent = 0;
            while (sent < PHASE_REQUESTS)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    // well-formed line, reads mixed in
                    small_pool = ($urandom_range(0, 1) == 1);
                    for (i = 0; i < 4; i++)
                        pool[i] = FIELD_W'($urandom);
                    len = $urandom_range(1, 24);
                    line_words.delete();
                    for (i = 0; i < len; i++)
                    begin
                        w = small_pool ? pool[$urandom_range(0, 3)] : FIELD_W'($urandom);
                        send_word(w);
                        line_words = {line_words, w};
                        sent++;
                        if ($urandom_range(0, 3) == 0)
                        begin
                            if ($urandom_range(0, 3) != 0)
                                send_read(line_words[$urandom_range(0, line_words.size() - 1)],
                                          line_words[$urandom_range(0, line_words.size() - 1)]);
                            else
                                send_read(FIELD_W'($urandom), FIELD_W'($urandom));
                            sent++;
                        end
                    end
                    // now and then a line runs on without its end mark
                    if ($urandom_range(0, 9) != 0)
                    begin
                        send_eol();
                        sent++;
                    end
                end
                else
                begin
                    // noise request, any code and any fields
                    w = FIELD_W'($urandom);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        send_request(REQ_UNUSED, w, FIELD_W'($urandom), FIELD_W'($urandom));
                    end
                    else
                    begin
                        send_request(REQ_W'($urandom_range(0, 2)), w,
                                     FIELD_W'($urandom), FIELD_W'($urandom));
                        sent++;
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_reads.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual weight_sum %h saturated %b",
                         $time, weight_sum, saturated);
                mismatch_count++;
            end
            else
            begin
                oldest_read = pending_reads.pop_front();
                if (weight_sum !== oldest_read.sum)
                begin
                    $display("%0t: weight_sum mismatch, expected %h actual %h",
                             $time, oldest_read.sum, weight_sum);
                    mismatch_count++;
                end
                if (saturated !== oldest_read.sat)
                begin
                    $display("%0t: saturated mismatch, expected %b actual %b",
                             $time, oldest_read.sat, saturated);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int d;
        start          = 1'b0;
        req_type       = REQ_WORD;
        word_index     = '0;
        row_index      = '0;
        col_index      = '0;
        cfg_valid      = 1'b0;
        window_length  = WINDOW_RESET;
        rst_n          = 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        pacing_on      = 1'b1;
        burst_left     = 0;

        // predictor reset state
        window_setting = WINDOW_RESET;
        line_depth     = 0;
        for (d = 0; d < VOCAB*VOCAB; d++)
        begin
            pair_total[d]    = '0;
            pair_sat_flag[d] = 1'b0;
        end
        for (d = 0; d < MAX_WIN; d++)
        begin
            line_history[d] = '0;
            weight_rom[d]   = WEIGHT_W'((131072 + d + 1) / (2 * (d + 1)));
        end

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_window_zero();
        test_random_traffic();
        drain_block();

        if (mismatch_count == 0 && pending_reads.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
